// ===== sv/triangle_tangent_bitangent_assert.svh =====
`ifndef TRIANGLE_TANGENT_BITANGENT_ASSERT_SVH
`define TRIANGLE_TANGENT_BITANGENT_ASSERT_SVH

// same-cycle implication
`define TBT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tbt assertion failed");

// next-cycle implication
`define TBT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tbt assertion failed");

`endif

// ===== sv/tbt_pkg.sv =====
package tbt_pkg;

	localparam int NFIELDS = 5;
	localparam int NOUT    = 6;

	typedef logic [2:0] job_t;

	localparam job_t JOB_DET  = 3'd0;
	localparam job_t JOB_TX   = 3'd1;
	localparam job_t JOB_TY   = 3'd2;
	localparam job_t JOB_TZ   = 3'd3;
	localparam job_t JOB_BX   = 3'd4;
	localparam job_t JOB_BY   = 3'd5;
	localparam job_t JOB_BZ   = 3'd6;
	localparam job_t JOB_LAST = JOB_BZ;

	localparam int F_X = 0;
	localparam int F_Y = 1;
	localparam int F_Z = 2;
	localparam int F_U = 3;
	localparam int F_V = 4;

	typedef struct packed {
		logic in_ready;
		logic load_first;
		logic load_second;
		logic load_third;
		logic mul_a;
		logic mul_b;
		logic check;
		logic div_load;
		logic div_step;
		logic write;
		logic publish;
		job_t job;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic out_busy;
		logic det_zero;
	} sts_t;

endpackage

// ===== sv/tbt_corner_if.sv =====
interface tbt_corner_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;
	logic signed [COORD_WIDTH-1:0] tex_u;
	logic signed [COORD_WIDTH-1:0] tex_v;

	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

// ===== sv/tbt_result_if.sv =====
interface tbt_result_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] tangent_x;
	logic signed [COORD_WIDTH-1:0] tangent_y;
	logic signed [COORD_WIDTH-1:0] tangent_z;
	logic signed [COORD_WIDTH-1:0] bitangent_x;
	logic signed [COORD_WIDTH-1:0] bitangent_y;
	logic signed [COORD_WIDTH-1:0] bitangent_z;
	logic degenerate;

	modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
		bitangent_y, bitangent_z, degenerate, input ready);
	modport sink (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
		bitangent_y, bitangent_z, degenerate, output ready);
endinterface

// ===== sv/tbt_ctrl.sv =====
`include "triangle_tangent_bitangent_assert.svh"

module tbt_ctrl
	import tbt_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int NW = 2 * COORD_WIDTH + FRAC_BITS + 4;
	localparam int CW = $clog2(NW);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MUL_A = 8'b0000_0010,
		S_MUL_B = 8'b0000_0100,
		S_CHECK = 8'b0000_1000,
		S_LOAD  = 8'b0001_0000,
		S_RUN   = 8'b0010_0000,
		S_WRITE = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t        state_q;
	logic [1:0]    cidx_q;
	job_t          job_q;
	logic [CW-1:0] cnt_q;
	logic          fire;

	always_comb begin
		cmd = '0;
		cmd.job = job_q;
		cmd.in_ready = (state_q == S_IDLE);
		fire = cmd.in_ready && sts.in_valid;
		cmd.load_first  = fire && (cidx_q != 2'd1) && (cidx_q != 2'd2);
		cmd.load_second = fire && (cidx_q == 2'd1);
		cmd.load_third  = fire && (cidx_q == 2'd2);
		cmd.mul_a    = (state_q == S_MUL_A);
		cmd.mul_b    = (state_q == S_MUL_B);
		cmd.check    = (state_q == S_CHECK);
		cmd.div_load = (state_q == S_LOAD);
		cmd.div_step = (state_q == S_RUN);
		cmd.write    = (state_q == S_WRITE);
		cmd.publish  = (state_q == S_DONE) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cidx_q  <= 2'd0;
			job_q   <= JOB_DET;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load_first) cidx_q <= 2'd1;
					if (cmd.load_second) cidx_q <= 2'd2;
					if (cmd.load_third) begin
						cidx_q  <= 2'd0;
						job_q   <= JOB_DET;
						state_q <= S_MUL_A;
					end
				end
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= (job_q == JOB_DET) ? S_CHECK : S_LOAD;
				S_CHECK: begin
					if (sts.det_zero) begin
						state_q <= S_DONE;
					end else begin
						job_q   <= job_q + job_t'(1);
						state_q <= S_MUL_A;
					end
				end
				S_LOAD: begin
					cnt_q   <= CW'(NW - 1);
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (cnt_q == '0) state_q <= S_WRITE;
					else cnt_q <= cnt_q - CW'(1);
				end
				S_WRITE: begin
					if (job_q == JOB_LAST) begin
						state_q <= S_DONE;
					end else begin
						job_q   <= job_q + job_t'(1);
						state_q <= S_MUL_A;
					end
				end
				S_DONE: begin
					if (!sts.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TBT_ASSERT_NEXT(a_third_starts, cmd.load_third, (state_q == S_MUL_A) && (job_q == JOB_DET))
	`TBT_ASSERT_NOW(a_publish_free, cmd.publish, !sts.out_busy)
	`TBT_ASSERT_NOW(a_write_job, cmd.write, (job_q != JOB_DET))

endmodule

// ===== sv/tbt_datapath.sv =====
module tbt_datapath
	import tbt_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	tbt_corner_if.sink   corner,
	tbt_result_if.source result
);

	localparam int W  = COORD_WIDTH;
	localparam int D  = W + 1;
	localparam int P  = 2 * D;
	localparam int N  = P + 1;
	localparam int NW = N + FRAC_BITS + 1;
	localparam int RW = N + 1;

	logic [W-1:0] c1_q [NFIELDS];
	logic [W-1:0] c2_q [NFIELDS];
	logic [W-1:0] cur  [NFIELDS];

	logic signed [D-1:0] dp1_q [3];
	logic signed [D-1:0] dp2_q [3];
	logic signed [D-1:0] du1_q, dv1_q, du2_q, dv2_q;

	logic signed [D-1:0] op_a, op_b;
	logic signed [P-1:0] prod, prod_q;
	logic signed [N-1:0] acc, det_q, num_q;
	logic [1:0]          idx;

	logic [NW-1:0] n_q;
	logic [RW-1:0] d_q, rem_q;
	logic [RW:0]   r2;
	logic [W:0]    q_q, lim, mag;
	logic          ovf_q, neg_q, qbit;
	logic [N-1:0]  a_mag, b_mag;
	logic [W-1:0]  res_val;
	logic [2:0]    ridx;

	logic [W-1:0] res_q [NOUT];
	logic         degen_q;
	logic [W-1:0] out_q [NOUT];
	logic         out_deg_q;
	logic         out_valid_q;

	assign cur[F_X] = corner.pos_x;
	assign cur[F_Y] = corner.pos_y;
	assign cur[F_Z] = corner.pos_z;
	assign cur[F_U] = corner.tex_u;
	assign cur[F_V] = corner.tex_v;

	assign corner.ready = cmd.in_ready;
	assign sts.in_valid = corner.valid;
	assign sts.out_busy = out_valid_q;
	assign sts.det_zero = (det_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load_first) for (int i = 0; i < NFIELDS; i++) c1_q[i] <= cur[i];
		if (cmd.load_second) for (int i = 0; i < NFIELDS; i++) c2_q[i] <= cur[i];
		if (cmd.load_third) begin
			for (int i = 0; i < 3; i++) begin
				dp1_q[i] <= $signed({c2_q[i][W-1], c2_q[i]}) - $signed({c1_q[i][W-1], c1_q[i]});
				dp2_q[i] <= $signed({cur[i][W-1], cur[i]}) - $signed({c1_q[i][W-1], c1_q[i]});
			end
			du1_q <= $signed({c2_q[F_U][W-1], c2_q[F_U]}) - $signed({c1_q[F_U][W-1], c1_q[F_U]});
			dv1_q <= $signed({c2_q[F_V][W-1], c2_q[F_V]}) - $signed({c1_q[F_V][W-1], c1_q[F_V]});
			du2_q <= $signed({cur[F_U][W-1], cur[F_U]}) - $signed({c1_q[F_U][W-1], c1_q[F_U]});
			dv2_q <= $signed({cur[F_V][W-1], cur[F_V]}) - $signed({c1_q[F_V][W-1], c1_q[F_V]});
		end
	end

	always_comb begin
		idx = 2'd0;
		op_a = '0;
		op_b = '0;
		unique case (cmd.job)
			JOB_DET: begin
				op_a = cmd.mul_b ? dv1_q : du1_q;
				op_b = cmd.mul_b ? du2_q : dv2_q;
			end
			JOB_TX, JOB_TY, JOB_TZ: begin
				idx  = 2'(cmd.job - JOB_TX);
				op_a = cmd.mul_b ? dp2_q[idx] : dp1_q[idx];
				op_b = cmd.mul_b ? dv1_q : dv2_q;
			end
			JOB_BX, JOB_BY, JOB_BZ: begin
				idx  = 2'(cmd.job - JOB_BX);
				op_a = cmd.mul_b ? dp1_q[idx] : dp2_q[idx];
				op_b = cmd.mul_b ? du2_q : du1_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod = op_a * op_b;
	assign acc  = N'(prod_q) - N'(prod);

	always_ff @(posedge clk) begin
		if (cmd.mul_a) prod_q <= prod;
		if (cmd.mul_b) begin
			if (cmd.job == JOB_DET) det_q <= acc;
			else num_q <= acc;
		end
	end

	assign a_mag = num_q[N-1] ? N'(-num_q) : N'(num_q);
	assign b_mag = det_q[N-1] ? N'(-det_q) : N'(det_q);
	assign r2    = {rem_q, n_q[NW-1]};
	assign qbit  = (r2 >= {1'b0, d_q});

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			n_q   <= (NW'(a_mag) << (FRAC_BITS + 1)) + NW'(b_mag);
			d_q   <= {b_mag, 1'b0};
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
			neg_q <= num_q[N-1] ^ det_q[N-1];
		end else if (cmd.div_step) begin
			n_q   <= {n_q[NW-2:0], 1'b0};
			rem_q <= qbit ? RW'(r2 - {1'b0, d_q}) : RW'(r2);
			q_q   <= {q_q[W-1:0], qbit};
			ovf_q <= ovf_q | q_q[W];
		end
	end

	assign lim     = neg_q ? ((W+1)'(1) << (W - 1)) : (((W+1)'(1) << (W - 1)) - (W+1)'(1));
	assign mag     = (ovf_q || (q_q > lim)) ? lim : q_q;
	assign res_val = neg_q ? W'(-mag) : W'(mag);
	assign ridx    = cmd.job - JOB_TX;

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			degen_q <= sts.det_zero;
			if (sts.det_zero) for (int i = 0; i < NOUT; i++) res_q[i] <= '0;
		end
		if (cmd.write) res_q[ridx] <= res_val;
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			for (int i = 0; i < NOUT; i++) out_q[i] <= res_q[i];
			out_deg_q <= degen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.tangent_x   = out_q[0];
	assign result.tangent_y   = out_q[1];
	assign result.tangent_z   = out_q[2];
	assign result.bitangent_x = out_q[3];
	assign result.bitangent_y = out_q[4];
	assign result.bitangent_z = out_q[5];
	assign result.degenerate  = out_deg_q;

endmodule

// ===== sv/triangle_tangent_bitangent.sv =====
// channel  role  payload
// corner   sink  pos_x pos_y pos_z tex_u tex_v
// result   src   tangent_x/y/z bitangent_x/y/z degenerate
//
// First and second corner of a triangle are only stored in registers.
// The third corner starts the determinant and then six quotients (tangent, bitangent),
// worked in turn on the shared multiplier and the one-bit-a-cycle restoring divider.
// A zero determinant ends the triangle without any division.
// Corners are not taken while a triangle is in work; a finished triangle also waits
// until the output register is free. Reset clears the corner count and result valid.
module triangle_tangent_bitangent
	import tbt_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input logic clk,
	input logic arst_n,
	tbt_corner_if.sink   corner,
	tbt_result_if.source result
);

	cmd_t cmd;
	sts_t sts;

	tbt_ctrl #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	tbt_datapath #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sts   (sts),
		.corner(corner),
		.result(result)
	);

endmodule

// ===== dv/triangle_tangent_bitangent_tb.sv =====
module triangle_tangent_bitangent_tb
	import tbt_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int RANDOM_ITEMS = 650;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 700;
	localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

	typedef logic signed [159:0] wide_t;
	typedef logic signed [CW-1:0] corner_t [NFIELDS];

	typedef struct packed {
		logic [CW-1:0] tx, ty, tz, bx, by, bz;
		logic deg;
	} frame_t;

	typedef struct {
		corner_t c;
		bit typed;
		frame_t r;
	} row_t;

	logic clk, arst_n;
	tbt_corner_if #(.COORD_WIDTH(CW)) corner ();
	tbt_result_if #(.COORD_WIDTH(CW)) result ();

	triangle_tangent_bitangent #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .corner(corner), .result(result)
	);

	frame_t frames_due[$];
	row_t rows[$];
	corner_t first_seen, second_seen;
	int seen_count = 0;
	int errors = 0;
	int cycles = 0;
	int triangles = 0;
	int flat_ones = 0;
	int frames_got = 0;
	bit stim_done = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [CW-1:0] fx_quot(wide_t num, wide_t den);
		logic neg;
		logic [159:0] a, b, q, lim;
		neg = (num < 0) != (den < 0);
		a = (num < 0) ? -num : num;
		b = (den < 0) ? -den : den;
		q = ((a << (FB + 1)) + b) / (b << 1);
		lim = neg ? (160'd1 << (CW - 1)) : ((160'd1 << (CW - 1)) - 1);
		if (q > lim)
			q = lim;
		return neg ? -q[CW-1:0] : q[CW-1:0];
	endfunction

	function automatic frame_t shade_frame(corner_t p1, corner_t p2, corner_t p3);
		frame_t f;
		wide_t d1 [NFIELDS];
		wide_t d2 [NFIELDS];
		wide_t det, tn, bn;
		logic [CW-1:0] t [3];
		logic [CW-1:0] bt [3];
		for (int i = 0; i < NFIELDS; i++) begin
			d1[i] = wide_t'(p2[i]) - wide_t'(p1[i]);
			d2[i] = wide_t'(p3[i]) - wide_t'(p1[i]);
		end
		det = d1[F_U] * d2[F_V] - d1[F_V] * d2[F_U];
		f = '0;
		if (det == 0) begin
			f.deg = 1'b1;
			return f;
		end
		for (int i = 0; i < 3; i++) begin
			tn = d1[i] * d2[F_V] - d2[i] * d1[F_V];
			bn = d2[i] * d1[F_U] - d1[i] * d2[F_U];
			t[i] = fx_quot(tn, det);
			bt[i] = fx_quot(bn, det);
		end
		f.tx = t[0]; f.ty = t[1]; f.tz = t[2];
		f.bx = bt[0]; f.by = bt[1]; f.bz = bt[2];
		return f;
	endfunction

	task automatic add_row(logic signed [CW-1:0] x, y, z, u, v, bit typed = 0,
			frame_t r = '0);
		row_t w;
		w.c[F_X] = x; w.c[F_Y] = y; w.c[F_Z] = z; w.c[F_U] = u; w.c[F_V] = v;
		w.typed = typed;
		w.r = r;
		rows.insert(rows.size(), w);
	endtask

	function automatic logic signed [CW-1:0] pick_value();
		unique case ($urandom_range(0, 9))
			0: return MAXV;
			1: return MINV;
			2: return $urandom_range(0, 1) ? -1 : 0;
			3, 4, 5: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_corner(corner_t c, bit typed, frame_t r);
		frame_t f;
		corner.valid <= 1'b1;
		corner.pos_x <= c[F_X];
		corner.pos_y <= c[F_Y];
		corner.pos_z <= c[F_Z];
		corner.tex_u <= c[F_U];
		corner.tex_v <= c[F_V];
		do @(posedge clk); while (!corner.ready);
		if (seen_count == 0) begin
			first_seen = c;
			seen_count = 1;
		end else if (seen_count == 1) begin
			second_seen = c;
			seen_count = 2;
		end else begin
			f = typed ? r : shade_frame(first_seen, second_seen, c);
			frames_due.insert(frames_due.size(), f);
			triangles++;
			if (f.deg)
				flat_ones++;
			seen_count = 0;
		end
	endtask

	int burst_left = 0;

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 8);
		if ($urandom_range(0, 2) != 0) begin
			corner.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	int stall_phase = 0;
	always @(posedge clk or negedge arst_n) begin
		frame_t want, got;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			stall_phase <= (stall_phase + 1) % 1500;
			result.ready <= (stall_phase < 300) ? 1'b1 : ($urandom_range(0, 3) == 0);
			if (result.valid && result.ready) begin
				frames_got <= frames_got + 1;
				got = {result.tangent_x, result.tangent_y, result.tangent_z,
					result.bitangent_x, result.bitangent_y, result.bitangent_z,
					result.degenerate};
				if (frames_due.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("unexpected result item %h", got);
				end else begin
					want = frames_due.pop_front();
					if (got.tx !== want.tx || got.ty !== want.ty || got.tz !== want.tz ||
							got.bx !== want.bx || got.by !== want.by ||
							got.bz !== want.bz || got.deg !== want.deg) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("result mismatch: expected %h got %h", want, got);
					end
				end
			end
		end
	end

	initial begin
		corner_t c1, c2, c3;
		frame_t flat, sat_pos, sat_neg;
		int kind;
		arst_n = 1'b0;
		corner.valid = 1'b0;
		corner.pos_x = '0;
		corner.pos_y = '0;
		corner.pos_z = '0;
		corner.tex_u = '0;
		corner.tex_v = '0;
		flat = '0; flat.deg = 1'b1;
		sat_pos = '0; sat_pos.tx = MAXV;
		sat_neg = '0; sat_neg.tx = MINV;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(0, 0, 0, 0, 0);
		add_row(0, 0, 0, 0, 0);
		add_row(0, 0, 0, 0, 0, 1, flat);
		add_row(0, 0, 0, 0, 0);
		add_row(MAXV, 0, 0, 1, 0);
		add_row(0, 0, 0, 0, 1, 1, sat_pos);
		add_row(0, 0, 0, 0, 0);
		add_row(MINV, 0, 0, 1, 0);
		add_row(0, 0, 0, 0, 1, 1, sat_neg);
		add_row(MINV, MINV, MINV, MINV, MINV);
		add_row(MAXV, MAXV, MAXV, MAXV, MINV);
		add_row(MINV, MAXV, MINV, MAXV, MAXV);
		add_row(32'h10000, 0, 0, 0, 0);
		add_row(0, 32'h10000, 0, 32'h10000, 0);
		add_row(0, 0, 32'h10000, 0, 32'h10000);
		add_row(-1, -1, -1, -1, -1);
		add_row(MAXV, MINV, MAXV, MINV, MAXV);
		add_row(1, 2, 3, MAXV, 7);
		add_row(MAXV, MAXV, MAXV, MAXV, MAXV);
		add_row(MINV, MINV, MINV, MINV, MINV);
		add_row(MAXV, MAXV, MAXV, MAXV, MAXV, 1, flat);
		foreach (rows[i]) begin
			send_corner(rows[i].c, rows[i].typed, rows[i].r);
			pace();
		end

		for (int t = 0; t < RANDOM_ITEMS / 3; t++) begin
			for (int i = 0; i < NFIELDS; i++) begin
				c1[i] = pick_value();
				c2[i] = pick_value();
				c3[i] = pick_value();
			end
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				c3[F_U] = c1[F_U];
				c3[F_V] = c1[F_V];
			end else if (kind == 1) begin
				c2[F_U] = c1[F_U];
				c3[F_U] = c1[F_U];
			end
			send_corner(c1, 0, '0);
			pace();
			send_corner(c2, 0, '0);
			pace();
			send_corner(c3, 0, '0);
			pace();
		end
		corner.valid <= 1'b0;

		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d triangles sent, %0d with zero determinant, %0d result items checked",
			triangles, flat_ones, frames_got);
		if (errors == 0 && frames_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+sv
sv/tbt_pkg.sv
sv/tbt_corner_if.sv
sv/tbt_result_if.sv
sv/tbt_ctrl.sv
sv/tbt_datapath.sv
sv/triangle_tangent_bitangent.sv
dv/triangle_tangent_bitangent_tb.sv
